>>> rtl/core/sfta_pkg.sv
// ----------------------------------------------------------------------------
// sfta_pkg: shared types and constants
// Constants, result kinds and search control for the strip/fan assembler.
// ----------------------------------------------------------------------------
package sfta_pkg;

	localparam int VertexSlotsDefault = 1024;
	localparam int SlotW = 11;
	localparam int RecW = 48;

	typedef enum logic [1:0] {
		KIND_NEW_VERTEX = 2'd0,
		KIND_TRIANGLE   = 2'd1,
		KIND_TABLE_FULL = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_COUNT = 3'd0,
		PH_VERT  = 3'd1,
		PH_NORM  = 3'd2,
		PH_S     = 3'd3,
		PH_T     = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SEARCH,
		ST_EMIT,
		ST_TRI
	} state_t;

	// handshake between the top level and the table search unit
	typedef struct packed {
		logic start;
		logic clear;
		logic hold;    // freeze the scan and hold back the outcome
	} srch_req_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic full;
	} srch_rsp_t;

endpackage

>>> rtl/core/sfta_table.sv
// ----------------------------------------------------------------------------
// sfta_table: vertex table with sequential search
// Scans entries one at a time, issuing a read and then comparing, through a
// synchronous memory; appends on a miss while room is left.
// ----------------------------------------------------------------------------
module sfta_table #(
	parameter int VERTEX_SLOTS = sfta_pkg::VertexSlotsDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sfta_pkg::srch_req_t        req,
	input  logic [sfta_pkg::RecW-1:0]  key,
	output sfta_pkg::srch_rsp_t        rsp,
	output logic [sfta_pkg::SlotW-1:0] slot
);
	localparam int AW = $clog2(VERTEX_SLOTS);
	localparam int CW = AW + 1;

	logic [sfta_pkg::RecW-1:0] mem [VERTEX_SLOTS];
	logic [sfta_pkg::RecW-1:0] rd_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] idx_q;
	logic          busy_q;
	logic          chk_q;
	logic [CW-1:0] chk_idx_q;
	logic          wr;

	// table read, registered
	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q[AW-1:0]];
		if (wr) begin
			mem[fill_q[AW-1:0]] <= key;
		end
	end

	always_comb begin
		rsp = '0;
		wr = 1'b0;
		slot = '0;
		if (busy_q && !req.hold && chk_q && rd_q == key) begin
			rsp.done = 1'b1;
			rsp.hit = 1'b1;
			slot = sfta_pkg::SlotW'(chk_idx_q);
		end else if (busy_q && !req.hold && !chk_q && idx_q >= fill_q) begin
			rsp.done = 1'b1;
			if (fill_q == CW'(VERTEX_SLOTS)) begin
				rsp.full = 1'b1;
				slot = sfta_pkg::SlotW'(VERTEX_SLOTS);
			end else begin
				wr = 1'b1;
				slot = sfta_pkg::SlotW'(fill_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q <= '0;
			busy_q <= 1'b0;
			chk_q <= 1'b0;
			chk_idx_q <= '0;
		end else begin
			if (req.clear) begin
				fill_q <= '0;
			end else if (wr) begin
				fill_q <= fill_q + 1'b1;
			end
			if (req.start) begin
				busy_q <= 1'b1;
				idx_q <= '0;
				chk_q <= 1'b0;
			end else if (rsp.done) begin
				busy_q <= 1'b0;
				chk_q <= 1'b0;
			end else if (busy_q && !req.hold) begin
				// alternate issue and compare so each read lands before the next
				if (chk_q) begin
					chk_q <= 1'b0;
					idx_q <= idx_q + 1'b1;
				end else begin
					chk_q <= 1'b1;
					chk_idx_q <= idx_q;
				end
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(VERTEX_SLOTS)) else $error("fill count past table");
	a_wr_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> fill_q < CW'(VERTEX_SLOTS)) else $error("append into full table");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> busy_q) else $error("done while idle");

endmodule

>>> rtl/core/strip_fan_triangle_assembler_unit.sv
// ----------------------------------------------------------------------------
// strip_fan_triangle_assembler_unit: triangle strip/fan primitive assembly
// Parses count/vertex words, looks up corners in a vertex table and emits
// appended-vertex, table-full and triangle beats.
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_axis   in   tdata = stream_word[15:0]; tuser = new_mesh
// m_axis   out  tdata = vertex_source,s_coord,t_coord,slot,corner_a/b/c;
//               tuser = kind,last; tlast = last
//
// Words that end no third-or-later vertex run no search. A closing t word runs
// three table searches; each scans the table an entry at a time, issuing a
// read and then comparing, through the single read port.
// Reset clears parser and fill count; table contents are valid below the fill.
// Output stalls hold the result register and the search; input is taken only when idle.
// ----------------------------------------------------------------------------
module strip_fan_triangle_assembler_unit #(
	parameter int VERTEX_SLOTS = sfta_pkg::VertexSlotsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,   // stream_word
	input  logic         s_axis_tuser,   // new_mesh
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// vertex_source[15:0] s_coord[31:16] t_coord[47:32] slot[58:48]
	// corner_a[69:59] corner_b[80:70] corner_c[91:81], zero pad to 96
	output logic [95:0]  m_axis_tdata,
	output logic [2:0]   m_axis_tuser,   // kind[1:0] last[2]
	output logic         m_axis_tlast
);
	localparam int SW = sfta_pkg::SlotW;

	sfta_pkg::state_t state_q, state_nx;
	sfta_pkg::phase_t phase_q;
	logic [15:0] left_q, seen_q;
	logic        fan_q;
	logic [47:0] asm_q, first_q, second_q, cur_q;
	logic [1:0]  corner_q;
	logic [SW-1:0] s0_q, s1_q, s2_q;
	sfta_pkg::srch_req_t req;
	sfta_pkg::srch_rsp_t rsp;
	logic [SW-1:0] slot;
	logic [47:0] key;
	logic        in_acc, out_free;
	logic        ov_q;
	logic [95:0] od_q;
	logic [2:0]  ou_q;
	logic        tri_now;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_free = !ov_q || m_axis_tready;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = od_q;
	assign m_axis_tuser = ou_q;
	assign m_axis_tlast = ou_q[2];

	// corner order: strips swap the held pair on odd triangles, fans never
	always_comb begin
		case (corner_q)
			2'd0: key = (!fan_q && seen_q[0]) ? second_q : first_q;
			2'd1: key = (!fan_q && seen_q[0]) ? first_q : second_q;
			default: key = cur_q;
		endcase
	end

	sfta_table #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_table (
		.clk(clk), .arst_n(arst_n), .req(req), .key(key), .rsp(rsp), .slot(slot)
	);

	// is the incoming word a t word closing a third-or-later vertex
	assign tri_now = phase_q == sfta_pkg::PH_T && seen_q >= 16'd2 && !s_axis_tuser;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			sfta_pkg::ST_IDLE: if (in_acc && tri_now) state_nx = sfta_pkg::ST_START;
			sfta_pkg::ST_START: state_nx = sfta_pkg::ST_SEARCH;
			sfta_pkg::ST_SEARCH: if (rsp.done && out_free) begin
				state_nx = (corner_q == 2'd2) ? sfta_pkg::ST_TRI : sfta_pkg::ST_START;
			end
			sfta_pkg::ST_TRI: if (out_free) state_nx = sfta_pkg::ST_IDLE;
			default: state_nx = sfta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = state_q == sfta_pkg::ST_IDLE;
		req.start = state_q == sfta_pkg::ST_START;
		req.clear = in_acc && s_axis_tuser;
		// hold the scan while a beat waits so no outcome is lost
		req.hold = !out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfta_pkg::ST_IDLE;
			phase_q <= sfta_pkg::PH_COUNT;
			left_q <= '0;
			seen_q <= '0;
			fan_q <= 1'b0;
			asm_q <= '0;
			first_q <= '0;
			second_q <= '0;
			cur_q <= '0;
			corner_q <= '0;
			s0_q <= '0;
			s1_q <= '0;
			s2_q <= '0;
			ov_q <= 1'b0;
			od_q <= '0;
			ou_q <= '0;
		end else begin
			state_q <= state_nx;
			if (ov_q && m_axis_tready) ov_q <= 1'b0;
			if (in_acc) begin
				// new mesh resets the parser before this word
				automatic sfta_pkg::phase_t ph = s_axis_tuser ? sfta_pkg::PH_COUNT : phase_q;
				automatic logic [15:0] sn = s_axis_tuser ? 16'd0 : seen_q;
				automatic logic [15:0] lf = s_axis_tuser ? 16'd0 : left_q;
				automatic logic [47:0] h1 = s_axis_tuser ? 48'd0 : first_q;
				automatic logic [47:0] h2 = s_axis_tuser ? 48'd0 : second_q;
				automatic logic [47:0] av = s_axis_tuser ? 48'd0 : asm_q;
				automatic logic [15:0] lf2 = (lf != 16'd0) ? lf - 16'd1 : 16'd0;
				if (s_axis_tuser) fan_q <= 1'b0;
				seen_q <= sn;
				left_q <= lf;
				first_q <= h1;
				second_q <= h2;
				asm_q <= av;
				phase_q <= ph;
				case (ph)
					sfta_pkg::PH_COUNT: if (s_axis_tdata != 16'd0) begin
						fan_q <= s_axis_tdata[15];
						left_q <= s_axis_tdata[15] ? 16'(17'h10000 - 17'(s_axis_tdata))
							: s_axis_tdata;
						seen_q <= '0;
						phase_q <= sfta_pkg::PH_VERT;
					end
					sfta_pkg::PH_VERT: begin
						asm_q <= {s_axis_tdata, 32'd0};
						phase_q <= sfta_pkg::PH_NORM;
					end
					sfta_pkg::PH_NORM: phase_q <= sfta_pkg::PH_S;
					sfta_pkg::PH_S: begin
						asm_q <= {av[47:32], s_axis_tdata, 16'd0};
						phase_q <= sfta_pkg::PH_T;
					end
					default: begin
						asm_q <= {av[47:16], s_axis_tdata};
						cur_q <= {av[47:16], s_axis_tdata};
						left_q <= lf2;
						phase_q <= (lf2 == 16'd0) ? sfta_pkg::PH_COUNT : sfta_pkg::PH_VERT;
						if (sn == 16'd0) first_q <= {av[47:16], s_axis_tdata};
						else if (sn == 16'd1) second_q <= {av[47:16], s_axis_tdata};
						corner_q <= '0;
						// seen advances after the triangle so the winding holds
						if (sn < 16'd2 && sn != 16'hFFFF) seen_q <= sn + 16'd1;
					end
				endcase
			end
			if (state_q == sfta_pkg::ST_SEARCH && rsp.done && out_free && !rsp.hit) begin
				ov_q <= 1'b1;
				od_q <= {4'd0, 33'd0, slot, key[15:0], key[31:16], key[47:32]};
				ou_q <= {1'b0, rsp.full ? sfta_pkg::KIND_TABLE_FULL : sfta_pkg::KIND_NEW_VERTEX};
			end
			if (state_q == sfta_pkg::ST_SEARCH && rsp.done && out_free) begin
				corner_q <= corner_q + 2'd1;
				if (corner_q == 2'd0) s0_q <= slot;
				if (corner_q == 2'd1) s1_q <= slot;
				if (corner_q == 2'd2) s2_q <= slot;
			end
			if (state_q == sfta_pkg::ST_TRI && out_free) begin
				ov_q <= 1'b1;
				od_q <= {4'd0, s2_q, s1_q, s0_q, 11'd0, 48'd0};
				ou_q <= {1'b1, sfta_pkg::KIND_TRIANGLE};
				if (fan_q) begin
					second_q <= cur_q;
				end else begin
					first_q <= second_q;
					second_q <= cur_q;
				end
				if (seen_q != 16'hFFFF) seen_q <= seen_q + 16'd1;
			end
		end
	end

	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != sfta_pkg::ST_IDLE |-> !s_axis_tready) else $error("input taken mid search");
	a_tri_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == sfta_pkg::KIND_TRIANGLE |-> m_axis_tlast)
		else $error("triangle not last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_axis_tvalid && !m_axis_tready) |-> $stable(m_axis_tdata))
		else $error("stalled beat changed");

endmodule
